[rtl/ecle_pkg.sv]
// Package for the console link engine: payload structs, state struct and codes.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package ecle_pkg;

  // Protocol limits.
  localparam logic [1:0]  OpenTries   = 2'd3;
  localparam logic [1:0]  DataRetries = 2'd2;
  localparam logic [10:0] HdrBytes    = 11'd18;
  localparam logic [10:0] CtrlBytes   = 11'd60;
  localparam logic [10:0] MaxPayload  = 11'd1482;

  // Event opcodes.
  localparam logic [2:0] OpOpen  = 3'd0;
  localparam logic [2:0] OpTick  = 3'd1;
  localparam logic [2:0] OpData  = 3'd2;
  localparam logic [2:0] OpRx    = 3'd3;
  localparam logic [2:0] OpClose = 3'd4;

  // Message kinds, received encoding.
  localparam logic [7:0] KindInitB = 8'd1;
  localparam logic [7:0] KindData  = 8'd3;
  localparam logic [7:0] KindAck   = 8'd4;
  localparam logic [7:0] KindOffer = 8'd6;
  localparam logic [7:0] KindReset = 8'd7;

  // Message kinds, transmitted encoding.
  localparam logic [2:0] TxInitA = 3'd0;
  localparam logic [2:0] TxInitC = 3'd2;
  localparam logic [2:0] TxData  = 3'd3;
  localparam logic [2:0] TxAck   = 3'd4;
  localparam logic [2:0] TxReset = 3'd7;

  // Link status events.
  localparam logic [2:0] EvNone       = 3'd0;
  localparam logic [2:0] EvOpened     = 3'd1;
  localparam logic [2:0] EvOpenFailed = 3'd2;
  localparam logic [2:0] EvTimedOut   = 3'd3;
  localparam logic [2:0] EvPeerReset  = 3'd4;
  localparam logic [2:0] EvPeerOffer  = 3'd5;
  localparam logic [2:0] EvClosed     = 3'd6;

  // Link states.
  localparam logic [1:0] StIdle      = 2'd0;
  localparam logic [1:0] StOpening   = 2'd1;
  localparam logic [1:0] StConnected = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CfgPeerAddr  = 2'd0;
  localparam logic [1:0] CfgEtherType = 2'd1;
  localparam logic [1:0] CfgConnTag   = 2'd2;

  localparam logic [7:0] RxSeqReset = 8'd255;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [10:0] local_len;
    logic [47:0] rx_src;
    logic [15:0] rx_etype;
    logic [7:0]  rx_kind;
    logic [7:0]  rx_tag;
    logic [7:0]  rx_seqno;
    logic [10:0] rx_len;
  } in_item_t;

  typedef struct packed {
    logic        tx_send;
    logic [2:0]  tx_kind;
    logic [7:0]  tx_seqno;
    logic [10:0] tx_frame_len;
    logic        deliver;
    logic [10:0] deliver_len;
    logic [2:0]  link_event;
  } out_item_t;

  typedef struct packed {
    logic [47:0] peer_addr;
    logic [15:0] ether_type;
    logic [7:0]  conn_tag;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  link_state;
    logic [1:0]  open_tries;
    logic [7:0]  send_seq;
    logic [7:0]  last_rx_seq;
    logic [10:0] unacked_len;
    logic [1:0]  retries_left;
  } link_t;

endpackage

[rtl/ethernet_console_link_engine_unit.sv]
// Top level of the console link engine: input register, event core, result register.
// Depends on ecle_pkg, ecle_cfg_regs and ecle_core.
//
// The engine takes one event per clock cycle while in_stall_o is low and returns exactly
// one result per event: the event is held in the input register, then the core updates
// the link state and loads the result register. Throughput is one event per cycle as
// long as the output side is not stalled; a stall on a held result holds both registers
// and reaches in_stall_o in the same cycle. No clearing pass is needed after reset.
// Configuration writes are always ready and should be issued only while the engine
// has no event in flight.
module ethernet_console_link_engine_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ecle_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ecle_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [47:0]         cfg_data_i
);

  ecle_pkg::cfg_t      cfg;
  ecle_pkg::in_item_t  in_q;
  logic                in_valid_q, in_valid_d;
  ecle_pkg::out_item_t out_q, res;
  logic                out_valid_q, out_valid_d;
  ecle_pkg::link_t     link_q, link_d;
  logic                advance;
  logic                in_take;

  assign cfg_ready_o = 1'b1;

  ecle_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ecle_core u_core (
    .item_i(in_q),
    .cfg_i (cfg),
    .link_i(link_q),
    .link_o(link_d),
    .res_o (res)
  );

  // The held event moves on when the result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q         <= 1'b0;
      out_valid_q        <= 1'b0;
      link_q.link_state   <= ecle_pkg::StIdle;
      link_q.open_tries   <= '0;
      link_q.send_seq     <= '0;
      link_q.last_rx_seq  <= ecle_pkg::RxSeqReset;
      link_q.unacked_len  <= '0;
      link_q.retries_left <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        link_q <= link_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Unused transmit fields read as zero when no frame is sent.
  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.tx_send) |->
      (out_data_o.tx_kind == '0 && out_data_o.tx_seqno == '0 &&
       out_data_o.tx_frame_len == '0))
    else $error("idle transmit fields are not zero");

  // Every delivery of received data goes out together with its ack.
  a_deliver_acks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.deliver) |->
      (out_data_o.tx_send && out_data_o.tx_kind == ecle_pkg::TxAck))
    else $error("delivery without ack");

  // An opened event leaves the link connected.
  a_opened_connects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.link_event == ecle_pkg::EvOpened) |=>
      (link_q.link_state == ecle_pkg::StConnected))
    else $error("opened event without connected state");

endmodule

[rtl/ecle_cfg_regs.sv]
// Configuration register file of the console link engine.
// Depends on ecle_pkg for the register indexes and the cfg_t struct.
module ecle_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [47:0]       cfg_data_i,
  output ecle_pkg::cfg_t    cfg_o
);

  ecle_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ecle_pkg::CfgPeerAddr:  cfg_d.peer_addr  = cfg_data_i;
        ecle_pkg::CfgEtherType: cfg_d.ether_type = cfg_data_i[15:0];
        ecle_pkg::CfgConnTag:   cfg_d.conn_tag   = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/ecle_core.sv]
// Event decoder and link state update of the console link engine, all combinational.
// Depends on ecle_pkg for the item, state and configuration structs and codes.
module ecle_core (
  input  ecle_pkg::in_item_t  item_i,
  input  ecle_pkg::cfg_t      cfg_i,
  input  ecle_pkg::link_t     link_i,
  output ecle_pkg::link_t     link_o,
  output ecle_pkg::out_item_t res_o
);

  logic [10:0] llen;
  logic [10:0] rlen;
  logic [1:0]  st;
  logic        from_peer;

  assign llen = (item_i.local_len > ecle_pkg::MaxPayload) ? ecle_pkg::MaxPayload
                                                          : item_i.local_len;
  assign rlen = (item_i.rx_len > ecle_pkg::MaxPayload) ? ecle_pkg::MaxPayload
                                                       : item_i.rx_len;
  // The unused fourth state code behaves as idle.
  assign st = (link_i.link_state == 2'd3) ? ecle_pkg::StIdle : link_i.link_state;
  assign from_peer = (item_i.rx_src == cfg_i.peer_addr) &&
                     (item_i.rx_etype == cfg_i.ether_type);

  always_comb begin
    link_o = link_i;
    res_o  = '0;
    unique case (item_i.opcode)
      ecle_pkg::OpOpen: begin
        link_o.link_state = ecle_pkg::StOpening;
        link_o.open_tries = 2'd1;
        res_o.tx_send      = 1'b1;
        res_o.tx_kind      = ecle_pkg::TxInitA;
        res_o.tx_frame_len = ecle_pkg::CtrlBytes;
      end
      ecle_pkg::OpTick: begin
        if (st == ecle_pkg::StOpening) begin
          if (link_i.open_tries < ecle_pkg::OpenTries) begin
            link_o.open_tries  = link_i.open_tries + 2'd1;
            res_o.tx_send      = 1'b1;
            res_o.tx_kind      = ecle_pkg::TxInitA;
            res_o.tx_frame_len = ecle_pkg::CtrlBytes;
          end else begin
            link_o.link_state = ecle_pkg::StIdle;
            res_o.link_event  = ecle_pkg::EvOpenFailed;
          end
        end else if (st == ecle_pkg::StConnected && link_i.unacked_len != '0) begin
          if (link_i.retries_left == '0) begin
            link_o.link_state = ecle_pkg::StIdle;
            res_o.link_event  = ecle_pkg::EvTimedOut;
          end else begin
            link_o.retries_left = link_i.retries_left - 2'd1;
            res_o.tx_send       = 1'b1;
            res_o.tx_kind       = ecle_pkg::TxData;
            res_o.tx_seqno      = link_i.send_seq;
            res_o.tx_frame_len  = ecle_pkg::HdrBytes + link_i.unacked_len;
          end
        end
      end
      ecle_pkg::OpData: begin
        if (st == ecle_pkg::StConnected) begin
          link_o.send_seq     = link_i.send_seq + 8'd1;
          link_o.unacked_len  = llen;
          link_o.retries_left = ecle_pkg::DataRetries;
          res_o.tx_send       = 1'b1;
          res_o.tx_kind       = ecle_pkg::TxData;
          res_o.tx_seqno      = link_i.send_seq + 8'd1;
          res_o.tx_frame_len  = ecle_pkg::HdrBytes + llen;
        end
      end
      ecle_pkg::OpRx: begin
        if (st == ecle_pkg::StOpening) begin
          if (item_i.rx_kind == ecle_pkg::KindInitB &&
              item_i.rx_etype == cfg_i.ether_type) begin
            link_o.link_state   = ecle_pkg::StConnected;
            link_o.send_seq     = '0;
            link_o.last_rx_seq  = ecle_pkg::RxSeqReset;
            link_o.unacked_len  = '0;
            link_o.retries_left = '0;
            res_o.tx_send       = 1'b1;
            res_o.tx_kind       = ecle_pkg::TxInitC;
            res_o.tx_frame_len  = ecle_pkg::CtrlBytes;
            res_o.link_event    = ecle_pkg::EvOpened;
          end
        end else if (st == ecle_pkg::StConnected && from_peer) begin
          // An offer ends the link whatever tag it carries.
          if (item_i.rx_kind == ecle_pkg::KindOffer) begin
            link_o.link_state = ecle_pkg::StIdle;
            res_o.link_event  = ecle_pkg::EvPeerOffer;
          end else if (item_i.rx_tag == cfg_i.conn_tag) begin
            if (item_i.rx_kind == ecle_pkg::KindData) begin
              if (item_i.rx_seqno != link_i.last_rx_seq) begin
                link_o.last_rx_seq = item_i.rx_seqno;
                res_o.deliver      = 1'b1;
                res_o.deliver_len  = rlen;
                res_o.tx_send      = 1'b1;
                res_o.tx_kind      = ecle_pkg::TxAck;
                res_o.tx_seqno     = item_i.rx_seqno;
                res_o.tx_frame_len = ecle_pkg::CtrlBytes;
              end
            end else if (item_i.rx_kind == ecle_pkg::KindAck) begin
              if (item_i.rx_seqno == link_i.send_seq) begin
                link_o.unacked_len = '0;
              end
            end else if (item_i.rx_kind == ecle_pkg::KindReset) begin
              link_o.link_state = ecle_pkg::StIdle;
              res_o.link_event  = ecle_pkg::EvPeerReset;
            end
          end
        end
      end
      ecle_pkg::OpClose: begin
        if (st == ecle_pkg::StOpening || st == ecle_pkg::StConnected) begin
          link_o.link_state  = ecle_pkg::StIdle;
          res_o.tx_send      = 1'b1;
          res_o.tx_kind      = ecle_pkg::TxReset;
          res_o.tx_frame_len = ecle_pkg::CtrlBytes;
          res_o.link_event   = ecle_pkg::EvClosed;
        end
      end
      default: ;
    endcase
  end

endmodule
